FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL. Bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/dte_pkg.sv
package dte_pkg;

   // One parsed date string, as handed from the parser to the converter.
   typedef struct packed {
      logic        good;
      logic [13:0] year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [18:0] secs;
   } dte_rec_type;

   typedef struct packed {
      logic        valid;
      dte_rec_type rec;
   } dte_push_type;

   // Month codes, March first so leap days fall at the end of the count.
   localparam logic [3:0] MON_MAR = 4'd1;
   localparam logic [3:0] MON_APR = 4'd2;
   localparam logic [3:0] MON_MAY = 4'd3;
   localparam logic [3:0] MON_JUN = 4'd4;
   localparam logic [3:0] MON_JUL = 4'd5;
   localparam logic [3:0] MON_AUG = 4'd6;
   localparam logic [3:0] MON_SEP = 4'd7;
   localparam logic [3:0] MON_OCT = 4'd8;
   localparam logic [3:0] MON_NOV = 4'd9;
   localparam logic [3:0] MON_DEC = 4'd10;
   localparam logic [3:0] MON_JAN = 4'd11;
   localparam logic [3:0] MON_FEB = 4'd12;

   // Positions inside "hh:mm:ss " and inside a trailing 4-digit year.
   localparam logic [3:0] TIME_COLON_A  = 4'd2;
   localparam logic [3:0] TIME_COLON_B  = 4'd5;
   localparam logic [3:0] TIME_LAST_POS = 4'd8;
   localparam logic [3:0] YEAR_LAST_POS = 4'd3;

   localparam logic [34:0] EPOCH_OFFSET = 35'd60652800;
   localparam logic [16:0] SEC_PER_DAY  = 17'd86400;

   function automatic logic [7:0] third_letter(input logic [3:0] m);
      logic [7:0] r;
      unique case (m)
         MON_APR: r = "r";
         MON_AUG: r = "g";
         MON_SEP: r = "p";
         MON_OCT: r = "t";
         MON_NOV: r = "v";
         MON_DEC: r = "c";
         MON_JAN: r = "n";
         MON_FEB: r = "b";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // floor(m * 520 / 17): days before month m from March, plus 30.
   function automatic logic [8:0] month_days(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd30;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd91;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd152;
         4'd6:    r = 9'd183;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd244;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd305;
         4'd11:   r = 9'd336;
         4'd12:   r = 9'd367;
         4'd13:   r = 9'd397;
         4'd14:   r = 9'd428;
         default: r = 9'd458;
      endcase
      return r;
   endfunction

   // Seconds that one time digit adds at its position.
   function automatic logic [18:0] time_term(input logic [3:0] pos, input logic [3:0] d);
      logic [18:0] r;
      unique case (pos)
         4'd0:    r = 19'(d) * 19'd36000;
         4'd1:    r = 19'(d) * 19'd3600;
         4'd3:    r = 19'(d) * 19'd600;
         4'd4:    r = 19'(d) * 19'd60;
         4'd6:    r = 19'(d) * 19'd10;
         4'd7:    r = 19'(d);
         default: r = 19'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/dte_front.sv
module dte_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_ch,
   input  logic                  req_last,
   input  logic                  q_full,
   output dte_pkg::dte_push_type push_o
);
   import dte_pkg::*;

   typedef enum logic [28:0] {
      S_WDAY    = 29'h0000001,
      S_LEAD    = 29'h0000002,
      S_DAY2    = 29'h0000004,
      S_DAYSEP  = 29'h0000008,
      S_MON1    = 29'h0000010,
      S_A2      = 29'h0000020,
      S_D2      = 29'h0000040,
      S_F2      = 29'h0000080,
      S_J2      = 29'h0000100,
      S_M2      = 29'h0000200,
      S_N2      = 29'h0000400,
      S_O2      = 29'h0000800,
      S_S2      = 29'h0001000,
      S_JU3     = 29'h0002000,
      S_MA3     = 29'h0004000,
      S_MLAST   = 29'h0008000,
      S_MSEP    = 29'h0010000,
      S_PRE     = 29'h0020000,
      S_PRE2    = 29'h0040000,
      S_ADAY2   = 29'h0080000,
      S_ADAYEND = 29'h0100000,
      S_YR2     = 29'h0200000,
      S_YR3     = 29'h0400000,
      S_YR4     = 29'h0800000,
      S_YREND   = 29'h1000000,
      S_TIME    = 29'h2000000,
      S_AYEAR   = 29'h4000000,
      S_DONE    = 29'h8000000,
      S_FAIL    = 29'h10000000
   } st_type;

   function automatic st_type month_first(input logic [7:0] c);
      st_type r;
      r = S_FAIL;
      if (c == "A") r = S_A2;
      if (c == "D") r = S_D2;
      if (c == "F") r = S_F2;
      if (c == "J") r = S_J2;
      if (c == "M") r = S_M2;
      if (c == "N") r = S_N2;
      if (c == "O") r = S_O2;
      if (c == "S") r = S_S2;
      return r;
   endfunction

   st_type      st_ff, st_in;
   logic [6:0]  day_ff, day_in;
   logic        dseen_ff, dseen_in;
   logic [3:0]  mon_ff, mon_in;
   logic [13:0] year_ff, year_in;
   logic        yseen_ff, yseen_in;
   logic [18:0] secs_ff, secs_in;
   logic [3:0]  pos_ff, pos_in;

   logic        acc, dig, sep;
   logic [3:0]  d;
   logic [6:0]  day_acc;
   logic [13:0] year_acc;

   assign req_ready = !q_full;
   assign acc       = req_valid && req_ready;
   assign dig       = (req_ch >= "0") && (req_ch <= "9");
   assign d         = req_ch[3:0];
   assign sep       = (req_ch == " ") || (req_ch == "-");
   assign day_acc   = 7'((10'(day_ff) * 10'd10) + 10'(d));
   assign year_acc  = 14'((18'(year_ff) * 18'd10) + 18'(d));

   always_comb begin
      st_in    = st_ff;
      day_in   = day_ff;
      dseen_in = dseen_ff;
      mon_in   = mon_ff;
      year_in  = year_ff;
      yseen_in = yseen_ff;
      secs_in  = secs_ff;
      pos_in   = pos_ff;
      push_o   = '0;
      if (acc) begin
         unique case (st_ff)
            S_WDAY: begin
               if (req_ch == " ") st_in = S_LEAD;
               else if (req_ch == 8'h00) st_in = S_FAIL;
            end
            S_LEAD: begin
               if (dig) begin
                  day_in   = 7'(d);
                  dseen_in = 1'b1;
                  st_in    = S_DAY2;
               end else begin
                  st_in = month_first(req_ch);
               end
            end
            S_DAY2: begin
               if (dig) begin
                  day_in = day_acc;
                  st_in  = S_DAYSEP;
               end else if (sep) st_in = S_MON1;
               else st_in = S_FAIL;
            end
            S_DAYSEP: st_in = sep ? S_MON1 : S_FAIL;
            S_MON1:   st_in = month_first(req_ch);
            S_A2: begin
               if (req_ch == "p") begin
                  mon_in = MON_APR;
                  st_in  = S_MLAST;
               end else if (req_ch == "u") begin
                  mon_in = MON_AUG;
                  st_in  = S_MLAST;
               end else st_in = S_FAIL;
            end
            S_D2: begin
               mon_in = MON_DEC;
               st_in  = (req_ch == "e") ? S_MLAST : S_FAIL;
            end
            S_F2: begin
               mon_in = MON_FEB;
               st_in  = (req_ch == "e") ? S_MLAST : S_FAIL;
            end
            S_N2: begin
               mon_in = MON_NOV;
               st_in  = (req_ch == "o") ? S_MLAST : S_FAIL;
            end
            S_O2: begin
               mon_in = MON_OCT;
               st_in  = (req_ch == "c") ? S_MLAST : S_FAIL;
            end
            S_S2: begin
               mon_in = MON_SEP;
               st_in  = (req_ch == "e") ? S_MLAST : S_FAIL;
            end
            S_J2: begin
               if (req_ch == "a") begin
                  mon_in = MON_JAN;
                  st_in  = S_MLAST;
               end else if (req_ch == "u") st_in = S_JU3;
               else st_in = S_FAIL;
            end
            S_M2: st_in = (req_ch == "a") ? S_MA3 : S_FAIL;
            S_JU3: begin
               if (req_ch == "n") begin
                  mon_in = MON_JUN;
                  st_in  = S_MSEP;
               end else if (req_ch == "l") begin
                  mon_in = MON_JUL;
                  st_in  = S_MSEP;
               end else st_in = S_FAIL;
            end
            S_MA3: begin
               if (req_ch == "r") begin
                  mon_in = MON_MAR;
                  st_in  = S_MSEP;
               end else if (req_ch == "y") begin
                  mon_in = MON_MAY;
                  st_in  = S_MSEP;
               end else st_in = S_FAIL;
            end
            S_MLAST: begin
               if ((third_letter(mon_ff) != 8'h00) && (req_ch == third_letter(mon_ff)))
                  st_in = S_MSEP;
               else
                  st_in = S_FAIL;
            end
            S_MSEP: st_in = sep ? S_PRE : S_FAIL;
            S_PRE, S_PRE2: begin
               if ((st_ff == S_PRE) && (req_ch == " ")) st_in = S_PRE2;
               else if (!dig) st_in = S_FAIL;
               else if (!dseen_ff) begin
                  day_in = 7'(d);
                  st_in  = S_ADAY2;
               end else begin
                  year_in  = 14'(d);
                  yseen_in = 1'b1;
                  st_in    = S_YR2;
               end
            end
            S_ADAY2: begin
               if (dig) begin
                  day_in = day_acc;
                  st_in  = S_ADAYEND;
               end else if (req_ch == " ") begin
                  pos_in = '0;
                  st_in  = S_TIME;
               end else st_in = S_FAIL;
            end
            S_YR2, S_YR3, S_YR4: begin
               if (dig) begin
                  year_in = year_acc;
                  priority if (st_ff == S_YR2) st_in = S_YR3;
                  else if (st_ff == S_YR3) st_in = S_YR4;
                  else st_in = S_YREND;
               end else if (req_ch == " ") begin
                  pos_in = '0;
                  st_in  = S_TIME;
               end else st_in = S_FAIL;
            end
            S_ADAYEND, S_YREND: begin
               pos_in = '0;
               st_in  = (req_ch == " ") ? S_TIME : S_FAIL;
            end
            S_TIME: begin
               priority if (pos_ff == TIME_LAST_POS) begin
                  pos_in = '0;
                  if (req_ch != " ") st_in = S_FAIL;
                  else st_in = yseen_ff ? S_DONE : S_AYEAR;
               end else if ((pos_ff == TIME_COLON_A) || (pos_ff == TIME_COLON_B)) begin
                  pos_in = pos_ff + 4'd1;
                  if (req_ch != ":") st_in = S_FAIL;
               end else begin
                  secs_in = secs_ff + time_term(pos_ff, d);
                  pos_in  = pos_ff + 4'd1;
                  if (!dig) st_in = S_FAIL;
               end
            end
            S_AYEAR: begin
               year_in = year_acc;
               pos_in  = pos_ff + 4'd1;
               if (!dig) st_in = S_FAIL;
               else if (pos_ff == YEAR_LAST_POS) st_in = S_DONE;
            end
            S_DONE, S_FAIL: st_in = st_ff;
            default: st_in = S_FAIL;
         endcase

         if (req_last) begin
            push_o.valid     = 1'b1;
            push_o.rec.good  = (st_in == S_DONE);
            push_o.rec.year  = year_in;
            push_o.rec.month = mon_in;
            push_o.rec.day   = day_in;
            push_o.rec.secs  = secs_in;
            st_in    = S_WDAY;
            day_in   = '0;
            dseen_in = 1'b0;
            mon_in   = '0;
            year_in  = '0;
            yseen_in = 1'b0;
            secs_in  = '0;
            pos_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_WDAY;
         day_ff   <= '0;
         dseen_ff <= 1'b0;
         mon_ff   <= '0;
         year_ff  <= '0;
         yseen_ff <= 1'b0;
         secs_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         day_ff   <= day_in;
         dseen_ff <= dseen_in;
         mon_ff   <= mon_in;
         year_ff  <= year_in;
         yseen_ff <= yseen_in;
         secs_ff  <= secs_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: rtl/dte_queue.sv
module dte_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dte_pkg::dte_push_type push_i,
   output logic                  q_full,
   output logic                  q_valid,
   output dte_pkg::dte_rec_type  q_rec,
   input  logic                  q_pop
);
   import dte_pkg::*;

   dte_rec_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_i.valid) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({push_i.valid, q_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_i.valid) begin
         mem_ff[wr_ptr_ff] <= push_i.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/dte_back.sv
module dte_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  dte_pkg::dte_rec_type q_rec,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_epoch_seconds,
   output logic                 rsp_ok
);
   import dte_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DAYS = 4'b0010,
      B_MUL  = 4'b0100,
      B_SUM  = 4'b1000
   } bst_type;

   bst_type     st_ff, st_in;
   dte_rec_type rec_ff;
   logic        good_ff;
   logic [15:0] days_ff;
   logic [32:0] prod_ff;
   logic        vld_ff, vld_in;
   logic [31:0] epoch_ff;
   logic        ok_ff;

   logic        in_range;
   logic [6:0]  yadj, ymon;
   logic [15:0] days_calc;
   logic [34:0] total;
   logic        total_ok;
   logic        out_free;

   // Fold the year to a March-based count that starts at 1968.
   always_comb begin
      in_range = 1'b1;
      yadj     = '0;
      priority if (rec_ff.year < 14'd70) yadj = 7'(rec_ff.year + 14'd32);
      else if (rec_ff.year < 14'd100) yadj = 7'(rec_ff.year - 14'd68);
      else if (rec_ff.year < 14'd1970) in_range = 1'b0;
      else if (rec_ff.year < 14'd2040) yadj = 7'(rec_ff.year - 14'd1968);
      else in_range = 1'b0;
      ymon = (rec_ff.month > MON_DEC) ? (yadj - 7'd1) : yadj;
      days_calc = (16'(ymon) * 16'd365) + 16'(ymon[6:2])
                + 16'(month_days(rec_ff.month)) + 16'(rec_ff.day);
   end

   assign total    = 35'(prod_ff) + 35'(rec_ff.secs) - EPOCH_OFFSET;
   assign total_ok = !total[34] && (total[33:32] == 2'b00);
   assign out_free = !vld_ff || rsp_ready;
   assign q_pop    = (st_ff == B_IDLE) && q_valid;

   always_comb begin
      st_in  = st_ff;
      vld_in = vld_ff && !rsp_ready;
      unique case (st_ff)
         B_IDLE: if (q_valid) st_in = B_DAYS;
         B_DAYS: st_in = B_MUL;
         B_MUL:  st_in = B_SUM;
         B_SUM: begin
            if (out_free) begin
               vld_in = 1'b1;
               st_in  = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff <= q_rec;
      end
      if (st_ff == B_DAYS) begin
         days_ff <= days_calc;
         good_ff <= rec_ff.good && in_range;
      end
      if (st_ff == B_MUL) begin
         prod_ff <= 33'(days_ff) * 33'(SEC_PER_DAY);
      end
      if ((st_ff == B_SUM) && out_free) begin
         ok_ff    <= good_ff && total_ok;
         epoch_ff <= (good_ff && total_ok) ? total[31:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_epoch_seconds = epoch_ff;
   assign rsp_ok            = ok_ff;

endmodule

FILE: rtl/http_date_to_epoch_seconds.sv
// HTTP date to Unix seconds.
// Request channel (req_valid/req_ready): one ASCII byte per request in req_ch,
// with req_last high on the final byte of the date string. The parser takes
// one request per cycle; req_ready drops only while two finished strings wait
// in the two-entry queue between the parser and the converter.
// Response channel (rsp_valid/rsp_ready): one response per string, issued for
// the request that carries req_last. rsp_ok is 1 when the date parsed and
// falls in 1970..2039, or has a two-digit year (00..69 read as 2000..2069);
// otherwise rsp_epoch_seconds is 0. When idle, the converter pops the record
// of a finished string, then runs day count, day-to-seconds multiply and
// final sum in turn; it pops the next record only after the sum, while the
// parser goes on taking the bytes of later strings.
// Stall: a held response parks in the output register; the converter waits
// behind it, the queue fills, and then req_ready falls.
// Reset (synchronous, active high): drop any partial string, empty the queue,
// and clear the pending response.
`include "assert_macros.svh"

module http_date_to_epoch_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_epoch_seconds,
   output logic        rsp_ok
);
   import dte_pkg::*;

   dte_push_type push;
   dte_rec_type  q_rec;
   logic         q_full;
   logic         q_valid;
   logic         q_pop;

   // Parse the byte stream; emit one record per string.
   dte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .q_full    (q_full),
      .push_o    (push)
   );

   // Hold finished records so parsing and conversion stall independently.
   dte_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_rec   (q_rec),
      .q_pop   (q_pop)
   );

   // Convert day, month, year and time into seconds since the epoch.
   dte_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_rec             (q_rec),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_ok            (rsp_ok)
   );

   `ASSERT_IMPL(a_no_push_when_full, clock, reset, q_full, !push.valid)
   `ASSERT_IMPL(a_no_pop_when_empty, clock, reset, !q_valid, !q_pop)
   `ASSERT_NEXT(a_pop_spacing, clock, reset, q_pop, !q_pop)
   `ASSERT_IMPL(a_fail_gives_zero, clock, reset, rsp_valid && !rsp_ok, rsp_epoch_seconds == '0)

endmodule
